/* design/csimp_pkg.sv */
package csimp_pkg;

  localparam int unsigned MantW   = 64;
  localparam int unsigned PlacesW = 5;
  localparam int unsigned UnitW   = 4;
  localparam logic [4:0]  Pow10Max = 5'd19;
  localparam logic [4:0]  MaxSig   = 5'd4;
  localparam logic [4:0]  UnitMax  = 5'd8;

  typedef struct packed {
    logic [MantW-1:0]   mantissa_in;
    logic [PlacesW-1:0] places_in;
    logic [UnitW-1:0]   unit_in;
  } in_word_t;

  typedef struct packed {
    logic [MantW-1:0]   mantissa_out;
    logic [PlacesW-1:0] places_out;
    logic [UnitW-1:0]   unit_out;
    logic               unit_overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle, StUnit, StDigits, StDivInit, StDiv, StRound, StFin, StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic unit_step;
    logic dig_step;
    logic div_init;
    logic div_step;
    logic round;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic unit_more;
    logic dig_more;
    logic rnd_need;
    logic div_last;
  } status_t;

  // powers of ten that fit in 64 bits; zero past the table
  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] p;
    unique case (n)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

/* design/csimp_ctrl.sv */
module csimp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_stall_i,
  input  csimp_pkg::status_t status_i,
  output csimp_pkg::cmd_t    cmd_o,
  output logic               in_stall_o,
  output logic               out_valid_o
);

  csimp_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csimp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csimp_pkg::StIdle:    if (in_valid_i) state_d = csimp_pkg::StUnit;
      csimp_pkg::StUnit:    if (!status_i.unit_more) state_d = csimp_pkg::StDigits;
      csimp_pkg::StDigits: begin
        if (!status_i.dig_more) begin
          state_d = status_i.rnd_need ? csimp_pkg::StDivInit : csimp_pkg::StFin;
        end
      end
      csimp_pkg::StDivInit: state_d = csimp_pkg::StDiv;
      csimp_pkg::StDiv:     if (status_i.div_last) state_d = csimp_pkg::StRound;
      csimp_pkg::StRound:   state_d = csimp_pkg::StFin;
      csimp_pkg::StFin:     state_d = csimp_pkg::StDone;
      csimp_pkg::StDone:    if (!out_stall_i) state_d = csimp_pkg::StIdle;
      default:              state_d = csimp_pkg::StIdle;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == csimp_pkg::StIdle) && in_valid_i;
    cmd_o.unit_step = (state_q == csimp_pkg::StUnit) && status_i.unit_more;
    cmd_o.dig_step  = (state_q == csimp_pkg::StDigits) && status_i.dig_more;
    cmd_o.div_init  = (state_q == csimp_pkg::StDivInit);
    cmd_o.div_step  = (state_q == csimp_pkg::StDiv);
    cmd_o.round     = (state_q == csimp_pkg::StRound);
    cmd_o.finish    = (state_q == csimp_pkg::StFin);
    in_stall_o      = (state_q != csimp_pkg::StIdle);
    out_valid_o     = (state_q == csimp_pkg::StDone);
  end

endmodule

/* design/csimp_dp.sv */
module csimp_dp #(
  parameter int unsigned MANTISSA_BITS = 64
) (
  input  logic                 clk_i,
  input  csimp_pkg::in_word_t  in_data_i,
  input  csimp_pkg::cmd_t      cmd_i,
  output csimp_pkg::status_t   status_o,
  output csimp_pkg::out_word_t out_data_o
);

  localparam int unsigned MB   = MANTISSA_BITS;
  localparam int unsigned CntW = $clog2(MB);
  localparam logic [CntW-1:0] CntLast = CntW'(MB - 1);

  logic [MB-1:0]   m_q, m_d;
  logic [MB-1:0]   rem_q, rem_d;
  logic [MB-1:0]   div_q, div_d;
  logic [4:0]      dp_q, dp_d;
  logic [4:0]      unit_q, unit_d;
  logic [4:0]      n_q, n_d;
  logic [4:0]      rdig_q, rdig_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  csimp_pkg::out_word_t out_q, out_d;

  logic [5:0]  dp3;
  logic [63:0] m_ext;
  logic [4:0]  sig_xs;
  logic [4:0]  rdig;
  logic [63:0] pow_rd;
  logic [MB:0] rem_sh;
  logic        sub_ok;
  logic        rnd_up;

  assign m_ext = 64'(m_q);
  assign dp3   = {1'b0, dp_q} + 6'd3;

  // integer part still 1000 or more: step one unit up
  assign status_o.unit_more = (dp3 <= {1'b0, csimp_pkg::Pow10Max}) &&
                              (m_ext >= csimp_pkg::pow10(dp3[4:0]));
  // digit count, one compare a cycle
  assign status_o.dig_more  = (n_q <= csimp_pkg::Pow10Max) &&
                              (m_ext >= csimp_pkg::pow10(n_q));
  assign status_o.rnd_need  = (n_q > csimp_pkg::MaxSig) && (dp_q != 5'd0);
  assign status_o.div_last  = (cnt_q == CntLast);

  // digits to drop, never more than the fraction digits
  assign sig_xs = n_q - csimp_pkg::MaxSig;
  assign rdig   = (sig_xs > dp_q) ? dp_q : sig_xs;
  assign pow_rd = csimp_pkg::pow10(rdig);

  // restoring divider step
  assign rem_sh = {rem_q, m_q[MB-1]};
  assign sub_ok = (rem_sh >= {1'b0, div_q});
  // half up: twice the remainder against the divisor
  assign rnd_up = ({rem_q, 1'b0} >= {1'b0, div_q});

  always_comb begin
    m_d    = m_q;
    rem_d  = rem_q;
    div_d  = div_q;
    dp_d   = dp_q;
    unit_d = unit_q;
    n_d    = n_q;
    rdig_d = rdig_q;
    cnt_d  = cnt_q;
    out_d  = out_q;
    if (cmd_i.load) begin
      m_d    = in_data_i.mantissa_in[MB-1:0];
      dp_d   = in_data_i.places_in;
      unit_d = {1'b0, in_data_i.unit_in};
      n_d    = 5'd1;
    end
    if (cmd_i.unit_step) begin
      unit_d = unit_q + 5'd1;
      dp_d   = dp3[4:0];
    end
    if (cmd_i.dig_step) begin
      n_d = n_q + 5'd1;
    end
    if (cmd_i.div_init) begin
      div_d  = pow_rd[MB-1:0];
      rem_d  = '0;
      cnt_d  = '0;
      rdig_d = rdig;
    end
    if (cmd_i.div_step) begin
      rem_d = sub_ok ? MB'(rem_sh - {1'b0, div_q}) : rem_sh[MB-1:0];
      m_d   = {m_q[MB-2:0], sub_ok};
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.round) begin
      m_d  = m_q + MB'(rnd_up);
      dp_d = dp_q - rdig_q;
    end
    // result word, unit saturated at yottabytes
    if (cmd_i.finish) begin
      out_d.mantissa_out  = 64'(m_q);
      out_d.places_out    = dp_q;
      if (unit_q > csimp_pkg::UnitMax) begin
        out_d.unit_out      = csimp_pkg::UnitMax[3:0];
        out_d.unit_overflow = 1'b1;
      end else begin
        out_d.unit_out      = unit_q[3:0];
        out_d.unit_overflow = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    dp_q   <= dp_d;
    unit_q <= unit_d;
    n_q    <= n_d;
    rdig_q <= rdig_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  assign out_data_o = out_q;

endmodule

/* design/capacity_unit_simplify_top.sv */
// channel | direction | handshake           | word
// in      | input     | in_valid_i/in_stall_o   | csimp_pkg::in_word_t
// out     | output    | out_valid_o/out_stall_i | csimp_pkg::out_word_t
//
// One word at a time: unit steps, then digit counting, then, when rounding
// is needed, the restoring divider and the rounding step; then the result
// word is registered and offered on the out channel.
// Reset clears only the controller; the datapath holds no reset.
// in_stall_o is high from acceptance until the result word is taken;
// the result holds while out_stall_i is high.
module capacity_unit_simplify_top #(
  parameter int unsigned MANTISSA_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  csimp_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output csimp_pkg::out_word_t out_data_o
);

  csimp_pkg::cmd_t    cmd;
  csimp_pkg::status_t status;

  csimp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  csimp_dp #(
    .MANTISSA_BITS (MANTISSA_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
